// File: design/egrbw_pkg.sv
package egrbw_pkg;

   // Stream buffer size in bytes; the length count saturates at this figure.
   localparam int unsigned BUFFER_BYTES = 1048576;
   localparam int unsigned LEN_BITS     = 21;
   localparam logic [LEN_BITS-1:0] LEN_CAP =
      (BUFFER_BYTES < 32'h001F_FFFF) ? LEN_BITS'(BUFFER_BYTES) : {LEN_BITS{1'b1}};

   // Bit cache geometry.
   localparam logic [5:0] CACHE_BITS = 6'd32;

   // Emulation prevention byte and the raw start code.
   localparam logic [7:0]  EPB_BYTE   = 8'h03;
   localparam logic [7:0]  EPB_LIMIT  = 8'h03;
   localparam logic [31:0] START_CODE = 32'h0000_0001;

   // Largest Exp-Golomb code number that can be coded in 32 bits.
   localparam logic [32:0] CODE_MAX = 33'h0_FFFF_FFFE;

   // Command codes.
   typedef enum logic [3:0] {
      MODE_PUT        = 4'd0,
      MODE_UE         = 4'd1,
      MODE_SE         = 4'd2,
      MODE_ALIGN_ZERO = 4'd3,
      MODE_ALIGN_ONE  = 4'd4,
      MODE_TRAILING   = 4'd5,
      MODE_FLUSH      = 4'd6,
      MODE_START_CODE = 4'd7,
      MODE_RESTART    = 4'd8
   } mode_type;

   // Step strobes from the controller to the datapath; at most one is high.
   typedef struct packed {
      logic capture;
      logic code;
      logic lz_group;
      logic lz_bit;
      logic put_first;
      logic put_second;
      logic load_flush;
      logic load_start;
      logic restart;
      logic emit;
      logic finish;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      mode_type mode;
      logic     out_free;
      logic     word_empty;
   } dp_status_type;

endpackage

// File: design/egrbw_ctrl.sv
module egrbw_ctrl
   import egrbw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   typedef enum logic [8:0] {
      ST_IDLE         = 9'b000000001,
      ST_DECODE       = 9'b000000010,
      ST_LZ_GROUP     = 9'b000000100,
      ST_LZ_BIT       = 9'b000001000,
      ST_PUT_FIRST    = 9'b000010000,
      ST_DRAIN_FIRST  = 9'b000100000,
      ST_PUT_SECOND   = 9'b001000000,
      ST_DRAIN_SECOND = 9'b010000000,
      ST_DONE         = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      two_phase;

   // Commands that append a second bit field after the first one.
   assign two_phase = (dp_status.mode == MODE_UE) || (dp_status.mode == MODE_SE) ||
                      (dp_status.mode == MODE_TRAILING);

   // Sequencing of datapath steps, one step per cycle unless a drain or the finish waits for the output register.
   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               state_in       = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (dp_status.mode)
               MODE_PUT, MODE_ALIGN_ZERO, MODE_ALIGN_ONE, MODE_TRAILING: begin
                  dp_cmd.put_first = 1'b1;
                  state_in         = ST_DRAIN_FIRST;
               end
               MODE_UE, MODE_SE: begin
                  dp_cmd.code = 1'b1;
                  state_in    = ST_LZ_GROUP;
               end
               MODE_FLUSH: begin
                  dp_cmd.load_flush = 1'b1;
                  state_in          = ST_DRAIN_SECOND;
               end
               MODE_START_CODE: begin
                  dp_cmd.load_start = 1'b1;
                  state_in          = ST_DRAIN_SECOND;
               end
               MODE_RESTART: begin
                  dp_cmd.restart = 1'b1;
                  state_in       = ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_LZ_GROUP: begin
            dp_cmd.lz_group = 1'b1;
            state_in        = ST_LZ_BIT;
         end
         ST_LZ_BIT: begin
            dp_cmd.lz_bit = 1'b1;
            state_in      = ST_PUT_FIRST;
         end
         ST_PUT_FIRST: begin
            dp_cmd.put_first = 1'b1;
            state_in         = ST_DRAIN_FIRST;
         end
         ST_DRAIN_FIRST: begin
            if (dp_status.word_empty) begin
               state_in = two_phase ? ST_PUT_SECOND : ST_DONE;
            end else if (dp_status.out_free) begin
               dp_cmd.emit = 1'b1;
            end
         end
         ST_PUT_SECOND: begin
            dp_cmd.put_second = 1'b1;
            state_in          = ST_DRAIN_SECOND;
         end
         ST_DRAIN_SECOND: begin
            if (dp_status.word_empty) begin
               state_in = ST_DONE;
            end else if (dp_status.out_free) begin
               dp_cmd.emit = 1'b1;
            end
         end
         ST_DONE: begin
            if (dp_status.out_free) begin
               dp_cmd.finish = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/egrbw_datapath.sv
module egrbw_datapath
   import egrbw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          dp_cmd,
   output dp_status_type       dp_status,
   input  logic [3:0]          req_mode,
   input  logic [31:0]         req_value,
   input  logic [5:0]          req_bit_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_data_byte,
   output logic                rsp_has_byte,
   output logic                rsp_last,
   output logic [LEN_BITS-1:0] rsp_stream_length,
   output logic                rsp_error
);

   // Captured transaction.
   mode_type      mode_ff, mode_in;
   logic [31:0]   value_ff, value_in;
   logic [5:0]    bit_count_ff, bit_count_in;

   // Writer state.
   logic [31:0]         cache_ff, cache_in;
   logic [5:0]          count_ff, count_in;
   logic [1:0]          hist_ff, hist_in;
   logic [LEN_BITS-1:0] written_ff, written_in;
   logic                err_ff, err_in;

   // Word being sent byte by byte.
   logic [31:0] word_ff, word_in;
   logic [2:0]  word_left_ff, word_left_in;
   logic        prevent_ff, prevent_in;

   // Exp-Golomb code number plus one and its bit length less one.
   logic [31:0] code_ff, code_in;
   logic [1:0]  grp_ff, grp_in;
   logic [7:0]  grp_byte_ff, grp_byte_in;
   logic [4:0]  len_ff, len_in;

   // Held-back byte, so the final one can carry the end marker.
   logic        pend_valid_ff, pend_valid_in;
   logic [7:0]  pend_byte_ff, pend_byte_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_data_byte_ff, rsp_data_byte_in;
   logic                rsp_has_byte_ff, rsp_has_byte_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [LEN_BITS-1:0] rsp_stream_length_ff, rsp_stream_length_in;
   logic                rsp_error_ff, rsp_error_in;
   logic                rsp_push;

   // Combinational helpers.
   logic [2:0]  gap;
   logic [31:0] gap_ones;
   logic [5:0]  put_count_clamped;
   logic [31:0] put_val;
   logic [5:0]  put_n;
   logic [31:0] put_bits;
   logic [6:0]  put_total;
   logic        put_fits;
   logic [5:0]  put_over;
   logic [5:0]  fit_shift;
   logic [31:0] cache_fit;
   logic [31:0] word_over;
   logic [31:0] cache_over;
   logic [31:0] neg_value;
   logic [32:0] code_raw;
   logic        clamped;
   logic [31:0] code_plus;
   logic [1:0]  grp_sel;
   logic [7:0]  grp_byte_sel;
   logic [2:0]  msb_pos;
   logic [7:0]  top_byte;
   logic        insert_epb;
   logic [7:0]  emit_byte;
   logic [LEN_BITS:0]   len_sum;
   logic [LEN_BITS-1:0] flush_length;

   // Zero or one padding up to the next byte boundary.
   assign gap      = 3'(3'd0 - count_ff[2:0]);
   assign gap_ones = ~(32'hFFFF_FFFF << gap);
   assign put_count_clamped = (bit_count_ff > CACHE_BITS) ? CACHE_BITS : bit_count_ff;

   // Operands of the bit field to append.
   always_comb begin
      put_val = '0;
      put_n   = '0;
      if (dp_cmd.put_second) begin
         if ((mode_ff == MODE_UE) || (mode_ff == MODE_SE)) begin
            put_val = code_ff;
            put_n   = {1'b0, len_ff} + 6'd1;
         end else begin
            put_n = {3'b000, gap};
         end
      end else begin
         case (mode_ff)
            MODE_PUT: begin
               put_val = value_ff;
               put_n   = put_count_clamped;
            end
            MODE_UE, MODE_SE: begin
               put_n = {1'b0, len_ff};
            end
            MODE_ALIGN_ZERO: begin
               put_n = {3'b000, gap};
            end
            MODE_ALIGN_ONE: begin
               put_val = gap_ones;
               put_n   = {3'b000, gap};
            end
            MODE_TRAILING: begin
               put_val = 32'd1;
               put_n   = 6'd1;
            end
            default: begin
               put_val = '0;
               put_n   = '0;
            end
         endcase
      end
   end

   // Cache insertion; on overflow the full word leaves and the rest starts afresh.
   assign put_bits   = put_val & ~(32'hFFFF_FFFF << put_n);
   assign put_total  = 7'(count_ff) + 7'(put_n);
   assign put_fits   = (put_total <= 7'd32);
   assign put_over   = 6'(put_total - 7'd32);
   assign fit_shift  = 6'(7'd32 - put_total);
   assign cache_fit  = cache_ff | (put_bits << fit_shift);
   assign word_over  = cache_ff | (put_bits >> put_over);
   assign cache_over = put_bits << 6'(CACHE_BITS - put_over);

   // Code number for ue and se, clamped to what fits in 32 bits.
   assign neg_value = 32'd0 - value_ff;
   always_comb begin
      if (mode_ff == MODE_SE) begin
         if ((value_ff != 32'd0) && !value_ff[31]) begin
            code_raw = {value_ff, 1'b0} - 33'd1;
         end else begin
            code_raw = {neg_value, 1'b0};
         end
      end else begin
         code_raw = {1'b0, value_ff};
      end
   end
   assign clamped   = (code_raw > CODE_MAX);
   assign code_plus = clamped ? 32'hFFFF_FFFF : (code_raw[31:0] + 32'd1);

   // Leading one search, first the byte group and then the bit inside it.
   always_comb begin
      if (code_ff[31:24] != 8'd0) begin
         grp_sel      = 2'd3;
         grp_byte_sel = code_ff[31:24];
      end else if (code_ff[23:16] != 8'd0) begin
         grp_sel      = 2'd2;
         grp_byte_sel = code_ff[23:16];
      end else if (code_ff[15:8] != 8'd0) begin
         grp_sel      = 2'd1;
         grp_byte_sel = code_ff[15:8];
      end else begin
         grp_sel      = 2'd0;
         grp_byte_sel = code_ff[7:0];
      end
   end

   always_comb begin
      msb_pos = '0;
      for (int i = 0; i < 8; i++) begin
         if (grp_byte_ff[i]) begin
            msb_pos = 3'(i);
         end
      end
   end

   // Emulation prevention: a 0x03 goes first when two zero bytes meet a byte of 0x03 or less.
   assign top_byte   = word_ff[31:24];
   assign insert_epb = prevent_ff && (hist_ff == 2'd2) && (top_byte <= EPB_LIMIT);
   assign emit_byte  = insert_epb ? EPB_BYTE : top_byte;

   // Stream length reported by flush.
   assign len_sum      = (LEN_BITS+1)'(written_ff) + (LEN_BITS+1)'(count_ff[2:0] != 3'd0);
   assign flush_length = (len_sum > (LEN_BITS+1)'(LEN_CAP)) ? LEN_CAP : len_sum[LEN_BITS-1:0];

   // Next state of every register.
   always_comb begin
      mode_in              = mode_ff;
      value_in             = value_ff;
      bit_count_in         = bit_count_ff;
      cache_in             = cache_ff;
      count_in             = count_ff;
      hist_in              = hist_ff;
      written_in           = written_ff;
      err_in               = err_ff;
      word_in              = word_ff;
      word_left_in         = word_left_ff;
      prevent_in           = prevent_ff;
      code_in              = code_ff;
      grp_in               = grp_ff;
      grp_byte_in          = grp_byte_ff;
      len_in               = len_ff;
      pend_valid_in        = pend_valid_ff;
      pend_byte_in         = pend_byte_ff;
      rsp_data_byte_in     = rsp_data_byte_ff;
      rsp_has_byte_in      = rsp_has_byte_ff;
      rsp_last_in          = rsp_last_ff;
      rsp_stream_length_in = rsp_stream_length_ff;
      rsp_error_in         = rsp_error_ff;
      rsp_push             = 1'b0;

      if (dp_cmd.capture) begin
         mode_in      = mode_type'(req_mode);
         value_in     = req_value;
         bit_count_in = req_bit_count;
         err_in       = 1'b0;
      end

      if (dp_cmd.code) begin
         code_in = code_plus;
         err_in  = err_ff | clamped;
      end

      if (dp_cmd.lz_group) begin
         grp_in      = grp_sel;
         grp_byte_in = grp_byte_sel;
      end

      if (dp_cmd.lz_bit) begin
         len_in = {grp_ff, msb_pos};
      end

      if (dp_cmd.put_first || dp_cmd.put_second) begin
         if (put_fits) begin
            cache_in = cache_fit;
            count_in = put_total[5:0];
         end else begin
            word_in      = word_over;
            word_left_in = 3'd4;
            prevent_in   = 1'b1;
            cache_in     = cache_over;
            count_in     = put_over;
         end
      end

      if (dp_cmd.load_flush) begin
         word_in      = cache_ff;
         word_left_in = count_ff[5:3];
         prevent_in   = 1'b1;
         cache_in     = cache_ff << {count_ff[5:3], 3'b000};
         count_in     = {3'b000, count_ff[2:0]};
      end

      if (dp_cmd.load_start) begin
         word_in      = START_CODE;
         word_left_in = 3'd4;
         prevent_in   = 1'b0;
         err_in       = err_ff | (count_ff != 6'd0);
      end

      if (dp_cmd.restart) begin
         cache_in   = '0;
         count_in   = '0;
         hist_in    = '0;
         written_in = '0;
      end

      if (dp_cmd.emit) begin
         if (pend_valid_ff) begin
            rsp_data_byte_in     = pend_byte_ff;
            rsp_has_byte_in      = 1'b1;
            rsp_last_in          = 1'b0;
            rsp_stream_length_in = '0;
            rsp_error_in         = 1'b0;
            rsp_push             = 1'b1;
         end
         pend_valid_in = 1'b1;
         pend_byte_in  = emit_byte;
         if (written_ff < LEN_CAP) begin
            written_in = written_ff + LEN_BITS'(1);
         end
         if (emit_byte == 8'd0) begin
            hist_in = (hist_ff == 2'd2) ? 2'd2 : (hist_ff + 2'd1);
         end else begin
            hist_in = 2'd0;
         end
         if (!insert_epb) begin
            word_in      = word_ff << 8;
            word_left_in = word_left_ff - 3'd1;
         end
      end

      if (dp_cmd.finish) begin
         rsp_data_byte_in     = pend_valid_ff ? pend_byte_ff : 8'd0;
         rsp_has_byte_in      = pend_valid_ff;
         rsp_last_in          = 1'b1;
         rsp_stream_length_in = (mode_ff == MODE_FLUSH) ? flush_length : '0;
         rsp_error_in         = err_ff;
         rsp_push             = 1'b1;
         pend_valid_in        = 1'b0;
      end

      if (rsp_push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and writer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cache_ff      <= '0;
         count_ff      <= '0;
         hist_ff       <= '0;
         written_ff    <= '0;
         err_ff        <= 1'b0;
         word_left_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cache_ff      <= cache_in;
         count_ff      <= count_in;
         hist_ff       <= hist_in;
         written_ff    <= written_in;
         err_ff        <= err_in;
         word_left_ff  <= word_left_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff              <= mode_in;
      value_ff             <= value_in;
      bit_count_ff         <= bit_count_in;
      word_ff              <= word_in;
      prevent_ff           <= prevent_in;
      code_ff              <= code_in;
      grp_ff               <= grp_in;
      grp_byte_ff          <= grp_byte_in;
      len_ff               <= len_in;
      pend_byte_ff         <= pend_byte_in;
      rsp_data_byte_ff     <= rsp_data_byte_in;
      rsp_has_byte_ff      <= rsp_has_byte_in;
      rsp_last_ff          <= rsp_last_in;
      rsp_stream_length_ff <= rsp_stream_length_in;
      rsp_error_ff         <= rsp_error_in;
   end

   // Status and outputs.
   assign dp_status.mode       = mode_ff;
   assign dp_status.out_free   = !rsp_valid_ff || rsp_ready;
   assign dp_status.word_empty = (word_left_ff == 3'd0);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_byte     = rsp_data_byte_ff;
   assign rsp_has_byte      = rsp_has_byte_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_stream_length = rsp_stream_length_ff;
   assign rsp_error         = rsp_error_ff;

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CACHE_BITS)
      else $error("Bit cache holds more than 32 bits.");

   a_word_drained: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.put_first || dp_cmd.put_second || dp_cmd.load_flush || dp_cmd.load_start)
         |-> (word_left_ff == 3'd0))
      else $error("New word loaded before the previous one was sent.");

   a_pend_empty: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.capture |-> !pend_valid_ff)
      else $error("A held-back byte survived the end of a transaction.");

   a_epb_holds_word: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.emit && insert_epb) |=> ((hist_ff == 2'd0) && $stable(word_left_ff)))
      else $error("Prevention byte did not clear the zero history or consumed a byte.");

   a_length_cap: assert property (@(posedge clock) disable iff (reset)
      written_ff <= LEN_CAP)
      else $error("Byte count exceeds the buffer size.");
`endif

endmodule

// File: design/exp_golomb_rbsp_bit_writer.sv
// Channel   Handshake              Payload
// req       req_valid/req_ready    req_mode, req_value, req_bit_count
// rsp       rsp_valid/rsp_ready    rsp_data_byte, rsp_has_byte, rsp_last,
//                                  rsp_stream_length, rsp_error
//
// One transaction is taken at a time. Restart and unused codes only decode; put and
// align add a cache put and its drain, flush a load and a drain, trailing bits two puts
// with drains, and ue and se the code step, the two-step leading one search and the two
// cache puts. Each stream byte, inserted 0x03 and start code bytes included, is a drain step.
// Reset is synchronous and empties the bit cache, zero history and byte count.
// A low rsp_ready stalls the byte drain; req_ready is high only between transactions.
module exp_golomb_rbsp_bit_writer
   import egrbw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [3:0]          req_mode,
   input  logic [31:0]         req_value,
   input  logic [5:0]          req_bit_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_data_byte,
   output logic                rsp_has_byte,
   output logic                rsp_last,
   output logic [LEN_BITS-1:0] rsp_stream_length,
   output logic                rsp_error
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Sequencer.
   egrbw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // Bit cache, byte emitter and output register.
   egrbw_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .dp_status         (dp_status),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .req_bit_count     (req_bit_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_has_byte      (rsp_has_byte),
      .rsp_last          (rsp_last),
      .rsp_stream_length (rsp_stream_length),
      .rsp_error         (rsp_error)
   );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top
   import egrbw_pkg::*;
();

   localparam int unsigned MAX_RESULTS  = 16;
   localparam int unsigned RANDOM_CMDS  = 85;
   localparam int unsigned HOLD_AFTER   = 60;
   localparam int unsigned HOLD_CYCLES  = 200;
   localparam int unsigned STALL_LIMIT  = 1500;
   localparam int unsigned DRAIN_CYCLES = 40;

   // Command codes that the block does not decode; it must answer them with an empty result.
   localparam logic [3:0] MODE_SPARE_FIRST = 4'd9;
   localparam logic [3:0] MODE_SPARE_LAST  = 4'd15;

   // How a directed row is checked: by the predictor, or against results written out here.
   typedef enum logic [1:0] {
      CHK_PREDICT,
      CHK_EMPTY,
      CHK_START_OK,
      CHK_START_ERR
   } check_kind_type;

   typedef struct packed {
      logic [3:0]     mode;
      logic [31:0]    value;
      logic [5:0]     count;
      check_kind_type chk;
   } cmd_row_type;

   typedef struct packed {
      logic [7:0]          data_byte;
      logic                has_byte;
      logic                last;
      logic [LEN_BITS-1:0] stream_length;
      logic                error;
   } stream_result_type;

   // Directed commands: empty stream, start codes with and without cached bits, put
   // extremes, Exp-Golomb clamping, alignment, trailing bits, spare codes and restart.
   localparam cmd_row_type DIRECTED_CMDS [25] = '{
      '{MODE_FLUSH,       32'h0000_0000, 6'd0,  CHK_EMPTY},
      '{MODE_START_CODE,  32'h0000_0000, 6'd0,  CHK_START_OK},
      '{MODE_PUT,         32'hFFFF_FFFF, 6'd0,  CHK_EMPTY},
      '{MODE_PUT,         32'hFFFF_FFFF, 6'd1,  CHK_PREDICT},
      '{MODE_START_CODE,  32'h0000_0000, 6'd0,  CHK_START_ERR},
      '{MODE_ALIGN_ZERO,  32'h0000_0000, 6'd0,  CHK_PREDICT},
      '{MODE_PUT,         32'h0000_0000, 6'd32, CHK_PREDICT},
      '{MODE_PUT,         32'h0000_0102, 6'd32, CHK_PREDICT},
      '{MODE_PUT,         32'hFFFF_FFFF, 6'd63, CHK_PREDICT},
      '{MODE_UE,          32'h0000_0000, 6'd0,  CHK_PREDICT},
      '{MODE_UE,          32'hFFFF_FFFF, 6'd0,  CHK_PREDICT},
      '{MODE_UE,          32'hFFFF_FFFE, 6'd0,  CHK_PREDICT},
      '{MODE_SE,          32'h8000_0000, 6'd0,  CHK_PREDICT},
      '{MODE_SE,          32'h7FFF_FFFF, 6'd0,  CHK_PREDICT},
      '{MODE_SE,          32'hFFFF_FFFF, 6'd0,  CHK_PREDICT},
      '{MODE_SE,          32'h0000_0000, 6'd0,  CHK_PREDICT},
      '{MODE_ALIGN_ONE,   32'h0000_0000, 6'd0,  CHK_PREDICT},
      '{MODE_TRAILING,    32'h0000_0000, 6'd0,  CHK_PREDICT},
      '{MODE_PUT,         32'h0000_0003, 6'd32, CHK_PREDICT},
      '{MODE_FLUSH,       32'h0000_0000, 6'd0,  CHK_PREDICT},
      '{MODE_SPARE_FIRST, 32'hFFFF_FFFF, 6'd63, CHK_EMPTY},
      '{MODE_SPARE_LAST,  32'h0000_0000, 6'd0,  CHK_EMPTY},
      '{MODE_RESTART,     32'h0000_0000, 6'd0,  CHK_EMPTY},
      '{MODE_FLUSH,       32'h0000_0000, 6'd0,  CHK_EMPTY},
      '{MODE_PUT,         32'h0000_0003, 6'd32, CHK_PREDICT}
   };

   logic                clock;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_ready;
   logic [3:0]          req_mode      = '0;
   logic [31:0]         req_value     = '0;
   logic [5:0]          req_bit_count = '0;
   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   logic [7:0]          rsp_data_byte;
   logic                rsp_has_byte;
   logic                rsp_last;
   logic [LEN_BITS-1:0] rsp_stream_length;
   logic                rsp_error;

   // Shadow copy of the writer state.
   logic [31:0] shadow_cache = '0;
   int unsigned shadow_fill  = 0;
   int unsigned shadow_zeros = 0;
   int unsigned shadow_count = 0;

   stream_result_type cmd_out[$];
   stream_result_type stream_due[$];

   int unsigned cmds_sent      = 0;
   int unsigned results_seen   = 0;
   int unsigned mismatches     = 0;
   int unsigned epb_predicted  = 0;
   int unsigned errs_predicted = 0;
   int unsigned quiet_cycles   = 0;

   exp_golomb_rbsp_bit_writer uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .req_bit_count     (req_bit_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_has_byte      (rsp_has_byte),
      .rsp_last          (rsp_last),
      .rsp_stream_length (rsp_stream_length),
      .rsp_error         (rsp_error)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // One stream byte leaves the writer; the length saturates and the zero run is tracked.
   function automatic void emit_raw_byte(input logic [7:0] b);
      if (cmd_out.size() >= MAX_RESULTS) return;
      cmd_out.push_back('{b, 1'b1, 1'b0, '0, 1'b0});
      if (shadow_count < LEN_CAP) shadow_count++;
      if (b == 8'h00) begin
         if (shadow_zeros < 2) shadow_zeros++;
      end else begin
         shadow_zeros = 0;
      end
   endfunction

   // A byte from the cache, preceded by a prevention byte after two zero bytes.
   function automatic void emit_stream_byte(input logic [7:0] b, input logic prevent);
      if (prevent && shadow_zeros >= 2 && b <= EPB_LIMIT) begin
         epb_predicted++;
         emit_raw_byte(EPB_BYTE);
      end
      emit_raw_byte(b);
   endfunction

   // Packs bits MSB first; a put that overflows the cache sends the full word.
   function automatic void pack_bits(input logic [31:0] bits, input int unsigned width);
      int unsigned total;
      int unsigned over;
      logic [31:0] v;
      logic [31:0] word;
      v = bits;
      if (width > 32) width = 32;
      if (width < 32) v = v & ((32'd1 << width) - 32'd1);
      total = shadow_fill + width;
      if (total <= 32) begin
         shadow_cache = shadow_cache | (v << (32 - total));
         shadow_fill  = total;
      end else begin
         over = total - 32;
         word = shadow_cache | (v >> over);
         repeat (4) begin
            emit_stream_byte(word[31:24], 1'b1);
            word = word << 8;
         end
         shadow_cache = v << (32 - over);
         shadow_fill  = over;
      end
   endfunction

   // Exp-Golomb code: leading zeros, then the code number plus one. Returns the clamp flag.
   function automatic logic pack_exp_golomb(input logic [32:0] code_num);
      logic        clamped;
      logic [31:0] c;
      logic [31:0] t;
      int unsigned len;
      clamped = 1'b0;
      if (code_num > CODE_MAX) begin
         code_num = CODE_MAX;
         clamped  = 1'b1;
      end
      c   = code_num[31:0] + 32'd1;
      t   = c;
      len = 0;
      while (t > 1) begin
         t = t >> 1;
         len++;
      end
      pack_bits('0, len);
      pack_bits(c, len + 1);
      return clamped;
   endfunction

   function automatic int unsigned align_gap();
      return (32 - shadow_fill) & 7;
   endfunction

   // Works out the results of one command and moves the shadow state on.
   function automatic void encode_command(input logic [3:0] mode, input logic [31:0] value,
                                          input logic [5:0] count);
      logic              err;
      int unsigned       len_out;
      int unsigned       g;
      logic [32:0]       code;
      stream_result_type tail;
      cmd_out.delete();
      err     = 1'b0;
      len_out = 0;
      case (mode)
         MODE_PUT: pack_bits(value, count);
         MODE_UE: err = pack_exp_golomb({1'b0, value});
         MODE_SE: begin
            // Positive values map to odd code numbers, the rest to even ones.
            if (value != 0 && !value[31]) code = ({1'b0, value} << 1) - 33'd1;
            else code = {1'b0, (~value + 32'd1)} << 1;
            err = pack_exp_golomb(code);
         end
         MODE_ALIGN_ZERO: pack_bits('0, align_gap());
         MODE_ALIGN_ONE: begin
            g = align_gap();
            pack_bits((32'd1 << g) - 32'd1, g);
         end
         MODE_TRAILING: begin
            pack_bits(32'd1, 1);
            pack_bits('0, align_gap());
         end
         MODE_FLUSH: begin
            repeat (shadow_fill >> 3) begin
               emit_stream_byte(shadow_cache[31:24], 1'b1);
               shadow_cache = shadow_cache << 8;
            end
            shadow_fill = shadow_fill & 7;
            len_out     = shadow_count + ((shadow_fill != 0) ? 1 : 0);
            if (len_out > LEN_CAP) len_out = LEN_CAP;
         end
         MODE_START_CODE: begin
            // The start code goes out raw; cached bits are kept but flagged.
            err = (shadow_fill != 0);
            for (int i = 3; i >= 0; i--) emit_raw_byte(START_CODE[8*i +: 8]);
         end
         MODE_RESTART: begin
            shadow_cache = '0;
            shadow_fill  = 0;
            shadow_zeros = 0;
            shadow_count = 0;
         end
         default: ;
      endcase
      if (cmd_out.size() == 0) cmd_out.push_back('0);
      tail               = cmd_out[cmd_out.size() - 1];
      tail.last          = 1'b1;
      tail.stream_length = len_out[LEN_BITS-1:0];
      tail.error         = err;
      cmd_out[cmd_out.size() - 1] = tail;
      if (err) errs_predicted++;
   endfunction

   // Payload with frequent zero and small bytes, so that prevention bytes are provoked.
   function automatic logic [31:0] zero_rich_word();
      logic [31:0] w;
      int unsigned r;
      for (int i = 0; i < 4; i++) begin
         r = $urandom_range(0, 9);
         if (r < 4) w[8*i +: 8] = 8'h00;
         else if (r < 6) w[8*i +: 8] = 8'($urandom_range(1, 3));
         else w[8*i +: 8] = 8'($urandom_range(0, 255));
      end
      return w;
   endfunction

   // Code value of random bit length, so that short and long codes both occur.
   function automatic logic [31:0] sized_value();
      int unsigned w;
      w = $urandom_range(0, 32);
      if (w == 32) return $urandom;
      return $urandom & ((32'd1 << w) - 32'd1);
   endfunction

   // Offers one command transaction and records what it must produce once accepted.
   task automatic issue_command(input logic [3:0] mode, input logic [31:0] value,
                                input logic [5:0] count, input check_kind_type chk);
      int unsigned gap;
      gap = ((cmds_sent % 32) >= 24) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_value     <= value;
      req_bit_count <= count;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      cmds_sent++;
      encode_command(mode, value, count);
      case (chk)
         CHK_PREDICT: foreach (cmd_out[i]) stream_due.push_back(cmd_out[i]);
         CHK_EMPTY: stream_due.push_back('{8'h00, 1'b0, 1'b1, '0, 1'b0});
         default: begin
            for (int i = 3; i >= 0; i--) begin
               stream_due.push_back('{START_CODE[8*i +: 8], 1'b1, (i == 0), '0,
                                      (i == 0) && (chk == CHK_START_ERR)});
            end
         end
      endcase
   endtask

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, stream_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Result side: random stalls, one long hold-off, and checking against the oldest
   // outstanding expectation.
   initial begin : drain_results
      stream_result_type got;
      stream_result_type want;
      int unsigned       gap;
      bit                hold_done;
      hold_done = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (results_seen == HOLD_AFTER && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = ((results_seen % 40) >= 30) ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         got = '{rsp_data_byte, rsp_has_byte, rsp_last, rsp_stream_length, rsp_error};
         results_seen++;
         if (stream_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Unexpected result: byte %02h has %0b last %0b len %0d err %0b",
                        got.data_byte, got.has_byte, got.last, got.stream_length, got.error);
            end
         end else begin
            want = stream_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Mismatch at result %0d:", results_seen);
                  $display("  expected byte %02h has %0b last %0b len %0d err %0b",
                           want.data_byte, want.has_byte, want.last, want.stream_length,
                           want.error);
                  $display("  actual   byte %02h has %0b last %0b len %0d err %0b",
                           got.data_byte, got.has_byte, got.last, got.stream_length,
                           got.error);
               end
            end
         end
      end
   end

   // Command side: reset, the directed table, then random commands.
   initial begin : run_stream
      int unsigned pick;
      int unsigned random_cmds;
      logic [31:0] v;
      logic [5:0]  n;
      random_cmds = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_CMDS[i]) begin
         issue_command(DIRECTED_CMDS[i].mode, DIRECTED_CMDS[i].value,
                       DIRECTED_CMDS[i].count, DIRECTED_CMDS[i].chk);
      end

      // Mostly well-formed slice syntax: puts and codes, closed by trailing bits, flush and
      // a start code; else aligns, lone trailing or flush, start codes, restarts, spare codes.
      while (random_cmds < RANDOM_CMDS) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            if ($urandom_range(0, 19) == 0) n = 6'($urandom_range(33, 63));
            else n = 6'($urandom_range(0, 32));
            issue_command(MODE_PUT, zero_rich_word(), n, CHK_PREDICT);
            random_cmds++;
         end else if (pick < 50) begin
            v = ($urandom_range(0, 32) == 0) ? 32'hFFFF_FFFF : sized_value();
            issue_command(MODE_UE, v, 6'($urandom_range(0, 63)), CHK_PREDICT);
            random_cmds++;
         end else if (pick < 62) begin
            v = sized_value();
            if ($urandom_range(0, 1) == 1) v = -v;
            if ($urandom_range(0, 32) == 0) v = 32'h8000_0000;
            issue_command(MODE_SE, v, 6'($urandom_range(0, 63)), CHK_PREDICT);
            random_cmds++;
         end else if (pick < 67) begin
            issue_command(MODE_ALIGN_ZERO, $urandom, 6'($urandom_range(0, 63)), CHK_PREDICT);
            random_cmds++;
         end else if (pick < 72) begin
            issue_command(MODE_ALIGN_ONE, $urandom, 6'($urandom_range(0, 63)), CHK_PREDICT);
            random_cmds++;
         end else if (pick < 78) begin
            issue_command(MODE_TRAILING, $urandom, 6'($urandom_range(0, 63)), CHK_PREDICT);
            random_cmds++;
         end else if (pick < 86) begin
            issue_command(MODE_FLUSH, $urandom, 6'($urandom_range(0, 63)), CHK_PREDICT);
            random_cmds++;
         end else if (pick < 94) begin
            issue_command(MODE_TRAILING, $urandom, 6'd0, CHK_PREDICT);
            issue_command(MODE_FLUSH, $urandom, 6'd0, CHK_PREDICT);
            issue_command(MODE_START_CODE, $urandom, 6'd0, CHK_PREDICT);
            random_cmds += 3;
         end else if (pick < 96) begin
            issue_command(MODE_START_CODE, $urandom, 6'($urandom_range(0, 63)), CHK_PREDICT);
            random_cmds++;
         end else if (pick < 98) begin
            issue_command(MODE_RESTART, $urandom, 6'($urandom_range(0, 63)), CHK_PREDICT);
            random_cmds++;
         end else begin
            issue_command(4'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)), $urandom,
                          6'($urandom_range(0, 63)), CHK_PREDICT);
            random_cmds++;
         end
      end
      req_valid <= 1'b0;

      // Let every outstanding result arrive, then watch for stray ones.
      while (stream_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (stream_due.size() != 0) begin
         $display("%0d expected results never arrived", stream_due.size());
      end
      $display("Ran %0d commands (%0d directed) giving %0d checked results.",
               cmds_sent, $size(DIRECTED_CMDS), results_seen);
      $display("Predicted %0d prevention bytes and %0d error flags; %0d mismatches.",
               epb_predicted, errs_predicted, mismatches);
      if (mismatches == 0 && stream_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
